// ===== hdl/lsct_pkg.sv =====
// Shared types and constants for the sector cache tag engine.
// No dependencies; imported by every module of the block.
package lsct_pkg;

  localparam int IDX_W  = 6;
  localparam int ADDR_W = 32;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] lba;
    logic              run_read_ok;
    logic              single_read_ok;
  } lsct_in_t;

  typedef struct packed {
    logic              status;
    logic              hit;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] sector_lba;
    logic              evicted;
    logic [ADDR_W-1:0] evicted_lba;
    logic              last;
  } lsct_out_t;

  // Control strobes from the sequencer to the cell row
  typedef struct packed {
    logic capture;
    logic move;
    logic insert;
    logic clear;
  } lsct_ctl_t;

endpackage

// ===== hdl/lsct_cell.sv =====
// One recency position of the tag row: valid, slot number and address.
// Depends on lsct_pkg for the address width.
module lsct_cell #(
  parameter int SW = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic                      clear_i,
  input  logic                      prev_valid_i,
  input  logic [SW-1:0]             prev_slot_i,
  input  logic [lsct_pkg::ADDR_W-1:0] prev_addr_i,
  input  logic [lsct_pkg::ADDR_W-1:0] key_i,
  output logic                      valid_o,
  output logic [SW-1:0]             slot_o,
  output logic [lsct_pkg::ADDR_W-1:0] addr_o,
  output logic                      match_o
);
  import lsct_pkg::*;

  logic              valid_q;
  logic [SW-1:0]     slot_q;
  logic [ADDR_W-1:0] addr_q;

  // Take the neighbor's entry on shift, drop on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      slot_q <= prev_slot_i;
      addr_q <= prev_addr_i;
    end
  end

  assign match_o = valid_q && (addr_q == key_i);
  assign valid_o = valid_q;
  assign slot_o  = slot_q;
  assign addr_o  = addr_q;

endmodule

// ===== hdl/lsct_chain.sv =====
// Row of tag cells kept in recency order, most recent at position 0.
// Depends on lsct_pkg and lsct_cell.
module lsct_chain #(
  parameter int CAP = 64,
  parameter int SW  = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsct_pkg::lsct_ctl_t         ctl_i,
  input  logic [lsct_pkg::ADDR_W-1:0] key_i,
  input  logic [SW-1:0]               inj_slot_i,
  input  logic [lsct_pkg::ADDR_W-1:0] inj_addr_i,
  output logic                        any_match_o,
  output logic                        hit_o,
  output logic [SW-1:0]               hit_slot_o,
  output logic [SW-1:0]               tail_slot_o,
  output logic [lsct_pkg::ADDR_W-1:0] tail_addr_o
);
  import lsct_pkg::*;

  logic [CAP-1:0]    match;
  logic [CAP-1:0]    match_q;
  logic [CAP-1:0]    shift_en;
  logic [CAP-1:0]    valid;
  logic [SW-1:0]     slot [CAP];
  logic [ADDR_W-1:0] addr [CAP];

  // Hold the match vector for a move to front
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (ctl_i.capture) begin
      match_q <= match;
    end
  end

  // A cell shifts when the hit sits at or below it, or on every insert
  always_comb begin
    for (int p = 0; p < CAP; p++) begin
      shift_en[p] = ctl_i.insert || (ctl_i.move && (|(match_q >> p)));
    end
  end

  // Pick the slot of the hit cell
  always_comb begin
    hit_slot_o = '0;
    for (int p = 0; p < CAP; p++) begin
      hit_slot_o = hit_slot_o | (match_q[p] ? slot[p] : '0);
    end
  end

  for (genvar p = 0; p < CAP; p++) begin : g_cell
    if (p == 0) begin : g_head
      lsct_cell #(.SW(SW)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (shift_en[p]),
        .clear_i      (ctl_i.clear),
        .prev_valid_i (1'b1),
        .prev_slot_i  (inj_slot_i),
        .prev_addr_i  (inj_addr_i),
        .key_i        (key_i),
        .valid_o      (valid[p]),
        .slot_o       (slot[p]),
        .addr_o       (addr[p]),
        .match_o      (match[p])
      );
    end else begin : g_body
      lsct_cell #(.SW(SW)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (shift_en[p]),
        .clear_i      (ctl_i.clear),
        .prev_valid_i (valid[p-1]),
        .prev_slot_i  (slot[p-1]),
        .prev_addr_i  (addr[p-1]),
        .key_i        (key_i),
        .valid_o      (valid[p]),
        .slot_o       (slot[p]),
        .addr_o       (addr[p]),
        .match_o      (match[p])
      );
    end
  end

  assign any_match_o = |match;
  assign hit_o       = |match_q;
  assign tail_slot_o = slot[CAP-1];
  assign tail_addr_o = valid[CAP-1] ? addr[CAP-1] : '0;

endmodule

// ===== hdl/lru_sector_cache_tags.sv =====
// Sector cache tag engine with LRU replacement and sequential read-ahead.
// Depends on lsct_pkg and lsct_chain.
//
// Tags sit in a row of cells ordered by recency and compared in parallel; one
// item is handled at a time. A flush clears the row and gives no result. A hit
// passes the compare and evaluate steps and then gives its result. A miss takes
// the same steps to the scan or the decision step; read-ahead scans following
// addresses, at most READAHEAD_MAX - 1 of them, then the decision step picks a
// run of at most READAHEAD_MAX sectors, a single sector or a read error, and
// each installed sector gives one result. The next item is taken in the cycle
// after the last result is given. Results wait in one output register; while a
// result stalls there, any step that gives a result waits.
module lru_sector_cache_tags #(
  parameter int CAPACITY      = 64,
  parameter int READAHEAD_MAX = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lsct_pkg::lsct_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lsct_pkg::lsct_out_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);
  import lsct_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(READAHEAD_MAX + 1);
  localparam bit RA_ALLOWED = (CAPACITY >= 4 * READAHEAD_MAX);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CMP    = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_INST   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic              ra_en_q;
  logic [CW-1:0]     count_q, count_d;
  logic [ADDR_W-1:0] last_miss_q, last_miss_d;
  logic [ADDR_W-1:0] lba_q;
  logic              run_ok_q, single_ok_q;
  logic [RW-1:0]     run_q, run_d;
  logic [RW-1:0]     inst_q, inst_d;
  logic              out_valid_q;
  lsct_out_t         out_q, out_d;
  logic              emit;

  lsct_ctl_t         ctl;
  logic [ADDR_W-1:0] key;
  logic [SW-1:0]     inj_slot;
  logic [ADDR_W-1:0] inj_addr;
  logic              any_match, hit;
  logic [SW-1:0]     hit_slot, tail_slot;
  logic [ADDR_W-1:0] tail_addr;

  logic              in_acc, out_free, full, seq_miss, scan_go;
  logic [ADDR_W:0]   probe;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign full        = (count_q == CW'(CAPACITY));
  assign probe       = {1'b0, lba_q} + (ADDR_W + 1)'(run_q);
  assign scan_go     = (run_q < RW'(READAHEAD_MAX)) && !probe[ADDR_W];
  assign seq_miss    = ra_en_q && RA_ALLOWED && (lba_q == last_miss_q + 32'd1);
  assign key         = (state_q == ST_SCAN) ? probe[ADDR_W-1:0] : lba_q;
  assign inj_addr    = (state_q == ST_INST) ? lba_q + ADDR_W'(inst_q) : lba_q;
  assign inj_slot    = (state_q == ST_INST) ? (full ? tail_slot : count_q[SW-1:0])
                                            : hit_slot;

  // Sequence one lookup through compare, evaluate, scan, decide and install; a flush clears the row from idle
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_miss_d = last_miss_q;
    run_d       = run_q;
    inst_d      = inst_q;
    ctl         = '0;
    emit        = 1'b0;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == ACT_FLUSH) begin
            ctl.clear = 1'b1;
            count_d   = '0;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        ctl.capture = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        run_d = RW'(1);
        if (hit) begin
          if (out_free) begin
            ctl.move          = 1'b1;
            emit              = 1'b1;
            out_d             = '0;
            out_d.status      = STATUS_OK;
            out_d.hit         = 1'b1;
            out_d.entry_index = IDX_W'(hit_slot);
            out_d.sector_lba  = lba_q;
            out_d.last        = 1'b1;
            state_d           = ST_IDLE;
          end
        end else begin
          state_d = seq_miss ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        if (!scan_go || any_match) begin
          state_d = ST_DECIDE;
        end else begin
          run_d = run_q + RW'(1);
        end
      end
      ST_DECIDE: begin
        if (run_q > RW'(1) && run_ok_q) begin
          last_miss_d = lba_q + ADDR_W'(run_q) - 32'd1;
          inst_d      = run_q - RW'(1);
          state_d     = ST_INST;
        end else begin
          last_miss_d = lba_q;
          if (single_ok_q) begin
            inst_d  = '0;
            state_d = ST_INST;
          end else if (out_free) begin
            emit             = 1'b1;
            out_d            = '0;
            out_d.status     = STATUS_ERR;
            out_d.sector_lba = lba_q;
            out_d.last       = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      ST_INST: begin
        if (out_free) begin
          ctl.insert        = 1'b1;
          emit              = 1'b1;
          out_d             = '0;
          out_d.status      = STATUS_OK;
          out_d.entry_index = IDX_W'(inj_slot);
          out_d.sector_lba  = inj_addr;
          out_d.evicted     = full;
          out_d.evicted_lba = full ? tail_addr : '0;
          out_d.last        = (inst_q == '0);
          if (!full) begin
            count_d = count_q + CW'(1);
          end
          if (inst_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            inst_d = inst_q - RW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ra_en_q     <= 1'b1;
      count_q     <= '0;
      last_miss_q <= '0;
      run_q       <= '0;
      inst_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_miss_q <= last_miss_d;
      run_q       <= run_d;
      inst_q      <= inst_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ra_en_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lba_q       <= in_data_i.lba;
      run_ok_q    <= in_data_i.run_read_ok;
      single_ok_q <= in_data_i.single_read_ok;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  lsct_chain #(.CAP(CAPACITY), .SW(SW)) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .key_i       (key),
    .inj_slot_i  (inj_slot),
    .inj_addr_i  (inj_addr),
    .any_match_o (any_match),
    .hit_o       (hit),
    .hit_slot_o  (hit_slot),
    .tail_slot_o (tail_slot),
    .tail_addr_o (tail_addr)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Fill count never passes capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("fill count beyond capacity");

  // A flush empties the fill count
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.action == ACT_FLUSH) |=> (count_q == '0))
    else $error("flush left entries counted");

  // A new result only comes out of a busy sequencer
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (state_q != ST_IDLE)) else $error("result emitted while idle");

  // A read error is a final miss with nothing evicted
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STATUS_ERR) |-> (out_q.last && !out_q.hit
      && !out_q.evicted)) else $error("malformed error result");

endmodule
